// ===== sv/nns_pkg.sv =====
// ----------------------------------------------------------------------------
// nns_pkg
// Types and constants shared by the nearest neighbor search block.
// ----------------------------------------------------------------------------
package nns_pkg;

	localparam int MAX_FACES   = 256;
	localparam int MAX_EIGENS  = 64;
	localparam int FACE_W      = $clog2(MAX_FACES);
	localparam int EIGEN_W     = $clog2(MAX_EIGENS);
	localparam int COEF_W      = 24;
	localparam int SQ_W        = 2 * COEF_W + 1;
	localparam int DIST_W      = SQ_W + EIGEN_W;
	localparam int FE_W        = FACE_W + EIGEN_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_W       = 9;
	localparam logic [15:0] CONF_SAT_K = 16'd49152;
	localparam logic signed [16:0] CONF_ONE = 17'sd16384;

	typedef enum logic [0:0] {
		REG_NUM_FACES  = 1'b0,
		REG_NUM_EIGENS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_REF,
		KIND_QRY,
		KIND_SRCH
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_SQ,
		ST_MUL,
		ST_CMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                     command;
		logic [7:0]               face_index;
		logic [5:0]               coeff_index;
		logic signed [COEF_W-1:0] coefficient;
		logic                     last_element;
	} item_t;

	typedef struct packed {
		logic [7:0]         nearest_index;
		logic [62:0]        min_distance;
		logic signed [15:0] confidence;
	} result_t;

	typedef struct packed {
		kind_t                    kind;
		logic [FACE_W-1:0]        face;
		logic [EIGEN_W-1:0]       pos;
		logic signed [COEF_W-1:0] coef;
	} word_t;

endpackage

// ===== sv/nns_front.sv =====
// ----------------------------------------------------------------------------
// nns_front
// Accepts input words, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module nns_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  nns_pkg::item_t item,
	output logic          busy,
	input  logic          full,
	output logic          push,
	output nns_pkg::word_t word
);
	import nns_pkg::*;

	logic  vld_s1;
	word_t word_s1;
	logic  accept;

	assign busy   = vld_s1 && full;
	assign push   = vld_s1 && !full;
	assign accept = start && !busy;
	assign word   = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.kind <= !item.command ? KIND_REF :
				(item.last_element ? KIND_SRCH : KIND_QRY);
			word_s1.face <= item.face_index[FACE_W-1:0];
			word_s1.pos  <= item.coeff_index[EIGEN_W-1:0];
			word_s1.coef <= item.coefficient;
		end
	end

endmodule

// ===== sv/nns_queue.sv =====
// ----------------------------------------------------------------------------
// nns_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module nns_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nns_pkg::word_t  wr_word,
	input  logic           pop,
	output nns_pkg::word_t  head,
	output logic           empty,
	output logic           full
);
	import nns_pkg::*;

	word_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");

endmodule

// ===== sv/nns_back.sv =====
// ----------------------------------------------------------------------------
// nns_back
// Executes queued words: stores coefficients, walks the reference memory
// and derives the confidence by a binary search.
// ----------------------------------------------------------------------------
module nns_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [8:0]           cfg_data,
	input  nns_pkg::word_t        head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 done,
	output nns_pkg::result_t      result
);
	import nns_pkg::*;

	logic signed [COEF_W-1:0] ref_mem [MAX_FACES*MAX_EIGENS];
	logic signed [COEF_W-1:0] q_mem [MAX_EIGENS];

	state_t state_q, state_d;
	logic   issue;

	logic [8:0]         num_faces_q;
	logic [6:0]         num_eigens_q;
	logic [FACE_W-1:0]  nf_m1_q;
	logic [EIGEN_W-1:0] ne_m1_q;
	logic [FE_W-1:0]    fe_q;
	logic [FACE_W-1:0]  f_q;
	logic [EIGEN_W-1:0] e_q;
	logic [FACE_W:0]    eff_nf;
	logic [EIGEN_W:0]   eff_ne;

	logic signed [COEF_W-1:0] ref_rd_s1, q_rd_s1;
	logic signed [COEF_W:0]   diff_s2;
	logic [SQ_W-1:0]          sq_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic last_e_s1, last_e_s2, last_e_s3;
	logic last_f_s1, last_f_s2, last_f_s3;
	logic [FACE_W-1:0] face_s1, face_s2, face_s3;
	logic signed [2*COEF_W+1:0] sq_full;

	logic [DIST_W-1:0] acc_q, best_q, sum;
	logic [FACE_W-1:0] best_idx_q;

	logic [15:0] lo_q, hi_q, mid_q, lo_n, hi_n;
	logic [23:0] a;
	logic [16:0] mid_sum;
	logic [47:0] asq_q;
	logic [62:0] prod_q;
	logic        fits, more;
	logic signed [16:0] conf;

	logic    done_q;
	result_t result_q;

	assign done   = done_q;
	assign result = result_q;

	assign eff_nf = (num_faces_q == '0) ? (FACE_W+1)'(1) :
		((num_faces_q > 9'(MAX_FACES)) ? (FACE_W+1)'(MAX_FACES) : num_faces_q[FACE_W:0]);
	assign eff_ne = (num_eigens_q == '0) ? (EIGEN_W+1)'(1) :
		((num_eigens_q > 7'(MAX_EIGENS)) ? (EIGEN_W+1)'(MAX_EIGENS) : num_eigens_q[EIGEN_W:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_faces_q  <= 9'd1;
			num_eigens_q <= 7'd1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NUM_FACES:  num_faces_q  <= cfg_data;
				REG_NUM_EIGENS: num_eigens_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign lo_n    = fits ? mid_q : lo_q;
	assign hi_n    = fits ? hi_q : mid_q;
	assign more    = (hi_n - lo_n) > 16'd1;
	assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign fits    = {4'b0, prod_q} <= {best_q, 12'b0};

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (head.kind == KIND_SRCH) state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				issue = 1'b1;
				if (e_q == ne_m1_q && f_q == nf_m1_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (vld_s3 && last_e_s3 && last_f_s3) state_d = ST_SQ;
			end
			ST_SQ:   state_d = ST_MUL;
			ST_MUL:  state_d = ST_CMP;
			ST_CMP:  state_d = more ? ST_SQ : ST_EMIT;
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == KIND_REF) begin
			ref_mem[{head.face, head.pos}] <= head.coef;
		end
		if (pop && head.kind != KIND_REF) begin
			q_mem[head.pos] <= head.coef;
		end
		ref_rd_s1 <= ref_mem[{f_q, e_q}];
		q_rd_s1   <= q_mem[e_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign sq_full = diff_s2 * diff_s2;

	always_ff @(posedge clk) begin
		last_e_s1 <= (e_q == ne_m1_q);
		last_f_s1 <= (f_q == nf_m1_q);
		face_s1   <= f_q;
		diff_s2   <= {q_rd_s1[COEF_W-1], q_rd_s1} - {ref_rd_s1[COEF_W-1], ref_rd_s1};
		last_e_s2 <= last_e_s1;
		last_f_s2 <= last_f_s1;
		face_s2   <= face_s1;
		sq_s3     <= sq_full[SQ_W-1:0];
		last_e_s3 <= last_e_s2;
		last_f_s3 <= last_f_s2;
		face_s3   <= face_s2;
	end

	assign sum = acc_q + {{(DIST_W-SQ_W){1'b0}}, sq_s3};
	assign a   = {mid_q, 8'b0} - {8'b0, mid_q};

	always_ff @(posedge clk) begin
		if (pop && head.kind == KIND_SRCH) begin
			f_q     <= '0;
			e_q     <= '0;
			nf_m1_q <= FACE_W'(eff_nf - 1'b1);
			ne_m1_q <= EIGEN_W'(eff_ne - 1'b1);
			fe_q    <= FE_W'(eff_nf * eff_ne);
			acc_q   <= '0;
		end else if (issue) begin
			e_q <= (e_q == ne_m1_q) ? '0 : e_q + 1'b1;
			if (e_q == ne_m1_q) f_q <= f_q + 1'b1;
		end
		if (vld_s3) begin
			if (last_e_s3) begin
				acc_q <= '0;
				if (face_s3 == '0 || sum < best_q) begin
					best_q     <= sum;
					best_idx_q <= face_s3;
				end
			end else begin
				acc_q <= sum;
			end
		end
		if (state_q == ST_DRAIN) begin
			lo_q  <= '0;
			hi_q  <= CONF_SAT_K;
			mid_q <= CONF_SAT_K;
		end
		if (state_q == ST_SQ) begin
			asq_q <= 48'(a) * 48'(a);
		end
		if (state_q == ST_MUL) begin
			prod_q <= 63'(asq_q) * 63'(fe_q);
		end
		if (state_q == ST_CMP) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_sum[16:1];
		end
	end

	assign conf = CONF_ONE - $signed({1'b0, lo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			result_q.nearest_index <= 8'(best_idx_q);
			result_q.min_distance  <= 63'(best_q);
			result_q.confidence    <= conf[15:0];
		end
	end

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (lo_q <= hi_q) && (mid_q <= hi_q))
		else $error("confidence search bounds crossed");
	a_walk_to_conf: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && last_e_s3 && last_f_s3) |=> (state_q == ST_SQ))
		else $error("last distance did not start the confidence search");
	a_issue_width: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (f_q <= nf_m1_q))
		else $error("reference walk ran past the face count");

endmodule

// ===== sv/nearest_neighbour_search_top.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbour_search_top
// Nearest neighbor search by squared Euclidean distance over a reference
// table of signed Q16.8 vectors.
// ----------------------------------------------------------------------------
// Reference loads and query coefficients are taken one word per cycle while
// busy is low into a four-word queue; busy rises only when that queue and the
// input register are full. A word marked as the last query coefficient starts
// a search that walks the reference memory one coefficient per cycle through
// the read, difference and square registers, then derives the confidence by a
// binary search of at most 17 tests, each through the ST_SQ, ST_MUL and ST_CMP
// states, and presents the result through ST_EMIT and the result register.
// Words queued behind a search wait for it. done pulses for one cycle with the
// result and cannot be held off.
module nearest_neighbour_search_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  nns_pkg::item_t   item,
	output logic            busy,
	output logic            done,
	output nns_pkg::result_t result,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [8:0]      cfg_data
);
	import nns_pkg::*;

	word_t front_word, head;
	logic  push, pop, full, empty;

	nns_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.full   (full),
		.push   (push),
		.word   (front_word)
	);

	nns_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_word (front_word),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	nns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.done      (done),
		.result    (result)
	);

endmodule
